// ----- design/poly_voice_envelope_engine_macros.svh -----
// assertion macros for the voice envelope engine checker
// needs i_clk and i_rst_n in the scope of use
`ifndef POLY_VOICE_ENVELOPE_ENGINE_MACROS_SVH
`define POLY_VOICE_ENVELOPE_ENGINE_MACROS_SVH

// same-cycle implication
`define PVEE_AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pvee check failed");

// next-cycle implication
`define PVEE_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pvee check failed");

`endif

// ----- design/pvee_pkg.sv -----
// shared codes and defaults for the voice envelope engine
// no dependencies
package pvee_pkg;

    localparam int VOICES_DEF   = 32;
    localparam int NUM_KEYS_DEF = 64;
    localparam int ENV_FULL_DEF = 16384;

    localparam int CFG_W    = 15;
    localparam int CNT_W    = 8;
    localparam int KEY_W    = 6;
    localparam int PH_W     = 32;
    localparam int IDX_O_W  = 5;
    localparam int RCNT_W   = 6;
    localparam int REQ_W    = 2;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int IN_TD_W  = 40;
    localparam int OUT_TD_W = 72;

    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON  = 2'd0,
        REQ_NOTE_OFF = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_NONE     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [2:0] {
        RG_ATTACK_STEP  = 3'd0,
        RG_DECAY_TARGET = 3'd1,
        RG_DECAY_STEP   = 3'd2,
        RG_SUS_TARGET   = 3'd3,
        RG_SUS_STEP     = 3'd4,
        RG_SUS_DIV      = 3'd5,
        RG_REL_STEP     = 3'd6,
        RG_PLUCK        = 3'd7
    } t_reg_idx;

endpackage

// ----- design/poly_voice_envelope_engine.sv -----
// Voice table with per-voice envelope: note-on claims a voice, note-off releases matching
// voices, a tick steps every active voice and streams one item per ringing voice.
// Voice state sits in one single-port-read synchronous memory (VOICES entries); active,
// release and key are held in flip-flops so allocation and note-off are handled directly
// in the idle state. A tick walks every voice: a read state per voice to fetch its memory
// entry, an update state per active voice to step and write it back (held while the output
// side stalls), then a closing state. Reset clears at once, no sweep.
module poly_voice_envelope_engine
    import pvee_pkg::*;
#(
    parameter int VOICES   = VOICES_DEF,
    parameter int NUM_KEYS = NUM_KEYS_DEF,
    parameter int ENV_FULL = ENV_FULL_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [APB_AW-1:0]   i_paddr,
    input  logic [APB_DW-1:0]   i_pwdata,
    output logic [APB_DW-1:0]   o_prdata,
    output logic                o_pready,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // key[5:0], phase_step[37:6], zero pad
    input  logic [IN_TD_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]    i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // voice_index[4:0], phase[36:5], envelope[51:37], pluck_left[59:52],
    // ring_count[65:60], zero pad
    output logic [OUT_TD_W-1:0] o_m_tdata,
    // ringing[0]
    output logic                o_m_tuser,
    output logic                o_m_tlast
);

    localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW   = $clog2(VOICES + 1);
    localparam int EW   = ($clog2(ENV_FULL + 1) > CFG_W) ? $clog2(ENV_FULL + 1) : CFG_W;
    localparam int KCW  = $clog2(NUM_KEYS + 1) + KEY_W;

    typedef struct packed {
        logic [PH_W-1:0]  phase;
        logic [PH_W-1:0]  step;
        logic [EW-1:0]    env;
        t_stage           stage;
        logic [CNT_W-1:0] sus_cnt;
        logic [CNT_W-1:0] pluck;
    } t_voice;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_UPD  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    // configuration
    logic [CFG_W-1:0] r_attack, r_dec_tgt, r_dec_step, r_sus_tgt, r_sus_step, r_rel_step;
    logic [CNT_W-1:0] r_sus_div, r_pluck;

    t_state           r_state, n_state;
    logic [VOICES-1:0] r_active, n_active, r_rel, n_rel;
    logic [KEY_W-1:0] r_key [VOICES];
    logic [VW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_cnt, n_cnt;

    t_voice           mem [VOICES];
    t_voice           r_rdata;
    logic             mem_we;
    logic [VW-1:0]    mem_waddr;
    t_voice           mem_wdata;

    logic             r_pv, n_pv;
    logic [VW-1:0]    r_p_idx, n_p_idx;
    logic [PH_W-1:0]  r_p_phase, n_p_phase;
    logic [EW-1:0]    r_p_env, n_p_env;
    logic [CNT_W-1:0] r_p_pluck, n_p_pluck;

    logic             r_ovalid;
    logic [IDX_O_W-1:0] r_o_idx, n_o_idx;
    logic [PH_W-1:0]  r_o_phase, n_o_phase;
    logic [CFG_W-1:0] r_o_env, n_o_env;
    logic [CNT_W-1:0] r_o_pluck, n_o_pluck;
    logic             r_o_ring, n_o_ring;
    logic [RCNT_W-1:0] r_o_cnt, n_o_cnt;
    logic             r_o_last, n_o_last;
    logic             load_out, out_free;

    logic             in_acc, cfg_wr;
    t_req             req;
    logic [KEY_W-1:0] in_key;
    logic [PH_W-1:0]  in_step;
    logic             key_ok;
    logic [VW-1:0]    pick_v;
    logic             found_free, found_rel;

    t_stage           cur_stage, new_stage;
    logic [EW:0]      e_new;
    logic [EW:0]      sum_a, sum_b;
    logic [CNT_W-1:0] sc_new, sc_inc, div_eff;
    logic             freed;
    logic             last_idx;

    assign o_pready  = 1'b1;
    assign cfg_wr    = i_psel & i_penable & i_pwrite;
    assign in_acc    = i_s_tvalid & o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign req       = t_req'(i_s_tuser);
    assign in_key    = i_s_tdata[KEY_W-1:0];
    assign in_step   = i_s_tdata[KEY_W +: PH_W];
    assign key_ok    = (in_key != '0) && (KCW'(in_key) < KCW'(NUM_KEYS));
    assign out_free  = !r_ovalid || i_m_tready;
    assign last_idx  = (r_idx == VW'(VOICES - 1));

    always_comb begin
        case (t_reg_idx'(i_paddr[4:2]))
            RG_ATTACK_STEP:  o_prdata = APB_DW'(r_attack);
            RG_DECAY_TARGET: o_prdata = APB_DW'(r_dec_tgt);
            RG_DECAY_STEP:   o_prdata = APB_DW'(r_dec_step);
            RG_SUS_TARGET:   o_prdata = APB_DW'(r_sus_tgt);
            RG_SUS_STEP:     o_prdata = APB_DW'(r_sus_step);
            RG_SUS_DIV:      o_prdata = APB_DW'(r_sus_div);
            RG_REL_STEP:     o_prdata = APB_DW'(r_rel_step);
            RG_PLUCK:        o_prdata = APB_DW'(r_pluck);
            default:         o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack   <= CFG_W'(512);
            r_dec_tgt  <= CFG_W'(12000);
            r_dec_step <= CFG_W'(16);
            r_sus_tgt  <= CFG_W'(8192);
            r_sus_step <= CFG_W'(1);
            r_sus_div  <= CNT_W'(4);
            r_rel_step <= CFG_W'(64);
            r_pluck    <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(i_paddr[4:2]))
                RG_ATTACK_STEP:  r_attack   <= i_pwdata[CFG_W-1:0];
                RG_DECAY_TARGET: r_dec_tgt  <= i_pwdata[CFG_W-1:0];
                RG_DECAY_STEP:   r_dec_step <= i_pwdata[CFG_W-1:0];
                RG_SUS_TARGET:   r_sus_tgt  <= i_pwdata[CFG_W-1:0];
                RG_SUS_STEP:     r_sus_step <= i_pwdata[CFG_W-1:0];
                RG_SUS_DIV:      r_sus_div  <= i_pwdata[CNT_W-1:0];
                RG_REL_STEP:     r_rel_step <= i_pwdata[CFG_W-1:0];
                RG_PLUCK:        r_pluck    <= i_pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // first free voice, else first in release, else voice 0
    always_comb begin
        pick_v     = '0;
        found_free = 1'b0;
        found_rel  = 1'b0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (r_active[v] && r_rel[v]) begin
                found_rel = 1'b1;
            end
        end
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!r_active[v]) begin
                found_free = 1'b1;
            end
        end
        if (found_free) begin
            for (int v = VOICES - 1; v >= 0; v--) begin
                if (!r_active[v]) pick_v = VW'(v);
            end
        end else if (found_rel) begin
            for (int v = VOICES - 1; v >= 0; v--) begin
                if (r_rel[v]) pick_v = VW'(v);
            end
        end
    end

    // envelope step of the voice read last cycle
    always_comb begin
        cur_stage = r_rel[r_idx] ? ST_RELEASE : r_rdata.stage;
        new_stage = cur_stage;
        e_new     = {1'b0, r_rdata.env};
        sc_new    = r_rdata.sus_cnt;
        freed     = 1'b0;
        sum_a     = '0;
        sum_b     = '0;
        sc_inc    = r_rdata.sus_cnt + CNT_W'(1);
        div_eff   = (r_sus_div == '0) ? CNT_W'(1) : r_sus_div;
        case (cur_stage)
            ST_ATTACK: begin
                sum_a = {1'b0, r_rdata.env} + (EW + 1)'(r_attack);
                if (sum_a >= (EW + 1)'(ENV_FULL)) begin
                    e_new     = (EW + 1)'(ENV_FULL);
                    new_stage = ST_DECAY;
                end else begin
                    e_new = sum_a;
                end
            end
            ST_DECAY: begin
                sum_a = (EW + 1)'(r_dec_tgt) + (EW + 1)'(r_dec_step);
                if ({1'b0, r_rdata.env} > sum_a) begin
                    e_new = {1'b0, r_rdata.env} - (EW + 1)'(r_dec_step);
                end else begin
                    e_new     = (EW + 1)'(r_dec_tgt);
                    new_stage = ST_SUSTAIN;
                    sc_new    = '0;
                end
            end
            ST_SUSTAIN: begin
                sum_b = (EW + 1)'(r_sus_tgt) + (EW + 1)'(r_sus_step);
                if ({1'b0, r_rdata.env} > (EW + 1)'(r_sus_tgt)) begin
                    if (r_sus_step == '0) begin
                        e_new = (EW + 1)'(r_sus_tgt);
                    end else if (sc_inc >= div_eff) begin
                        sc_new = '0;
                        if ({1'b0, r_rdata.env} > sum_b) begin
                            e_new = {1'b0, r_rdata.env} - (EW + 1)'(r_sus_step);
                        end else begin
                            e_new = (EW + 1)'(r_sus_tgt);
                        end
                    end else begin
                        sc_new = sc_inc;
                    end
                end else begin
                    e_new = (EW + 1)'(r_sus_tgt);
                end
            end
            ST_RELEASE: begin
                if (r_rel_step == '0 || {1'b0, r_rdata.env} <= (EW + 1)'(r_rel_step)) begin
                    freed = 1'b1;
                end else begin
                    e_new = {1'b0, r_rdata.env} - (EW + 1)'(r_rel_step);
                end
            end
            default: e_new = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_rel     = r_rel;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_pv      = r_pv;
        n_p_idx   = r_p_idx;
        n_p_phase = r_p_phase;
        n_p_env   = r_p_env;
        n_p_pluck = r_p_pluck;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rdata;
        load_out  = 1'b0;
        n_o_idx   = IDX_O_W'(r_p_idx);
        n_o_phase = r_p_phase;
        n_o_env   = r_p_env[CFG_W-1:0];
        n_o_pluck = r_p_pluck;
        n_o_ring  = 1'b1;
        n_o_cnt   = '0;
        n_o_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (req)
                        REQ_NOTE_ON: begin
                            if (key_ok && in_step != '0) begin
                                mem_we            = 1'b1;
                                mem_waddr         = pick_v;
                                mem_wdata.phase   = '0;
                                mem_wdata.step    = in_step;
                                mem_wdata.env     = '0;
                                mem_wdata.stage   = ST_ATTACK;
                                mem_wdata.sus_cnt = '0;
                                mem_wdata.pluck   = r_pluck;
                                n_active[pick_v]  = 1'b1;
                                n_rel[pick_v]     = 1'b0;
                            end
                        end
                        REQ_NOTE_OFF: begin
                            if (key_ok) begin
                                for (int v = 0; v < VOICES; v++) begin
                                    if (r_active[v] && r_key[v] == in_key) n_rel[v] = 1'b1;
                                end
                            end
                        end
                        REQ_TICK: begin
                            n_idx   = '0;
                            n_cnt   = '0;
                            n_pv    = 1'b0;
                            n_state = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                if (r_active[r_idx]) begin
                    n_state = S_UPD;
                end else if (last_idx) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + VW'(1);
                end
            end
            S_UPD: begin
                if (freed) begin
                    n_active[r_idx] = 1'b0;
                    n_rel[r_idx]    = 1'b0;
                    n_state         = last_idx ? S_FIN : S_RD;
                    n_idx           = last_idx ? r_idx : r_idx + VW'(1);
                end else if (!r_pv || out_free) begin
                    load_out          = r_pv;
                    mem_we            = 1'b1;
                    mem_wdata.phase   = r_rdata.phase + r_rdata.step;
                    mem_wdata.env     = e_new[EW-1:0];
                    mem_wdata.stage   = new_stage;
                    mem_wdata.sus_cnt = sc_new;
                    mem_wdata.pluck   = (r_rdata.pluck != '0) ? r_rdata.pluck - CNT_W'(1) : '0;
                    n_pv      = 1'b1;
                    n_p_idx   = r_idx;
                    n_p_phase = r_rdata.phase + r_rdata.step;
                    n_p_env   = e_new[EW-1:0];
                    n_p_pluck = r_rdata.pluck;
                    n_cnt     = r_cnt + CW'(1);
                    n_state   = last_idx ? S_FIN : S_RD;
                    n_idx     = last_idx ? r_idx : r_idx + VW'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_o_last = 1'b1;
                    n_pv     = 1'b0;
                    n_state  = S_IDLE;
                    if (r_pv) begin
                        n_o_cnt = RCNT_W'(r_cnt);
                    end else begin
                        n_o_idx   = '0;
                        n_o_phase = '0;
                        n_o_env   = '0;
                        n_o_pluck = '0;
                        n_o_ring  = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_rel    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            for (int v = 0; v < VOICES; v++) r_key[v] <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_rel    <= n_rel;
            r_pv     <= n_pv;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_IDLE && in_acc && req == REQ_NOTE_ON && key_ok && in_step != '0) begin
                r_key[pick_v] <= in_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx   <= n_p_idx;
        r_p_phase <= n_p_phase;
        r_p_env   <= n_p_env;
        r_p_pluck <= n_p_pluck;
        if (load_out) begin
            r_o_idx   <= n_o_idx;
            r_o_phase <= n_o_phase;
            r_o_env   <= n_o_env;
            r_o_pluck <= n_o_pluck;
            r_o_ring  <= n_o_ring;
            r_o_cnt   <= n_o_cnt;
            r_o_last  <= n_o_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_o_cnt, r_o_pluck, r_o_env, r_o_phase, r_o_idx};
    assign o_m_tuser  = r_o_ring;
    assign o_m_tlast  = r_o_last;

endmodule

// ----- design/pvee_checker.sv -----
// port-level checks for the voice envelope engine, bound to the top level
// depends on pvee_pkg and the macro header
`include "poly_voice_envelope_engine_macros.svh"
module pvee_checker
    import pvee_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [REQ_W-1:0]    i_s_tuser,
    input logic                o_m_tvalid,
    input logic [OUT_TD_W-1:0] o_m_tdata,
    input logic                o_m_tuser,
    input logic                o_m_tlast,
    input logic                o_pready
);

    // ring count only on the closing item
    `PVEE_AST_NOW(a_cnt_last, o_m_tvalid && !o_m_tlast, o_m_tdata[65:60] == 6'd0)
    // a quiet item closes its tick
    `PVEE_AST_NOW(a_quiet_last, o_m_tvalid && !o_m_tuser, o_m_tlast)
    // a ringing closing item counts at least one voice
    `PVEE_AST_NOW(a_cnt_nz, o_m_tvalid && o_m_tlast && o_m_tuser, o_m_tdata[65:60] != 6'd0)
    // a tick holds off the input side
    `PVEE_AST_NXT(a_tick_busy, i_s_tvalid && o_s_tready && i_s_tuser == REQ_TICK, !o_s_tready)
    // the register port never waits
    `PVEE_AST_NOW(a_pready, 1'b1, o_pready)

endmodule

bind poly_voice_envelope_engine pvee_checker u_pvee_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast),
    .o_pready   (o_pready)
);

// ----- bench/tb_poly_voice_envelope_engine.sv -----
`timescale 1ns / 1ps
// self-checking bench for poly_voice_envelope_engine: streams note and tick items,
// predicts every reported voice item and compares them in order
// depends on pvee_pkg and the engine rtl
module tb_poly_voice_envelope_engine;
    import pvee_pkg::*;

    localparam int NV = VOICES_DEF;

    typedef struct {
        t_req        req;
        logic [5:0]  key;
        logic [31:0] pstep;
    } note_req_t;

    typedef struct packed {
        logic [4:0]  vidx;
        logic [31:0] phase;
        logic [14:0] env;
        logic [7:0]  pluck;
        logic        ringing;
        logic [5:0]  rcount;
        logic        last;
    } voice_out_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_psel = 1'b0;
    logic                i_penable = 1'b0;
    logic                i_pwrite = 1'b0;
    logic [APB_AW-1:0]   i_paddr = '0;
    logic [APB_DW-1:0]   i_pwdata = '0;
    logic [APB_DW-1:0]   o_prdata;
    logic                o_pready;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // key[5:0], phase_step[37:6], zero pad
    logic [IN_TD_W-1:0]  i_s_tdata = '0;
    // req_type[1:0]
    logic [REQ_W-1:0]    i_s_tuser = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // voice_index[4:0], phase[36:5], envelope[51:37], pluck_left[59:52],
    // ring_count[65:60], zero pad
    logic [OUT_TD_W-1:0] o_m_tdata;
    // ringing[0]
    logic                o_m_tuser;
    logic                o_m_tlast;

    poly_voice_envelope_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    note_req_t   pend_q[$];
    voice_out_t  voice_exp_q[$];
    int          n_sent = 0;
    int          n_taken = 0;
    int          errors = 0;
    bit          hold_go = 0;

    // predictor state
    int unsigned atk_step = 512, dec_target = 12000, dec_step = 16, sus_target = 8192;
    int unsigned sus_step = 1, sus_div = 4, rel_step = 64;
    logic [7:0]  pluck_init = 0;
    bit          v_act[NV];
    logic [5:0]  v_key[NV];
    logic [31:0] v_ph[NV];
    logic [31:0] v_ps[NV];
    int unsigned v_env[NV];
    t_stage      v_stg[NV];
    logic [7:0]  v_sc[NV];
    logic [7:0]  v_pl[NV];

    task automatic free_voice(int v);
        v_act[v] = 0; v_key[v] = 0; v_ph[v] = 0; v_ps[v] = 0;
        v_env[v] = 0; v_stg[v] = ST_OFF; v_sc[v] = 0; v_pl[v] = 0;
    endtask

    task automatic step_env(int v);
        int unsigned e;
        int unsigned dv;
        e = v_env[v];
        case (v_stg[v])
            ST_ATTACK: begin
                if (e + atk_step >= ENV_FULL_DEF) begin
                    e = ENV_FULL_DEF;
                    v_stg[v] = ST_DECAY;
                end else begin
                    e += atk_step;
                end
            end
            ST_DECAY: begin
                if (e > dec_target + dec_step) begin
                    e -= dec_step;
                end else begin
                    e = dec_target;
                    v_stg[v] = ST_SUSTAIN;
                    v_sc[v] = 0;
                end
            end
            ST_SUSTAIN: begin
                if (e > sus_target) begin
                    if (sus_step == 0) begin
                        e = sus_target;
                    end else begin
                        dv = (sus_div != 0) ? sus_div : 1;
                        v_sc[v] = v_sc[v] + 8'd1;
                        if (v_sc[v] >= dv) begin
                            v_sc[v] = 0;
                            if (e > sus_target + sus_step) e -= sus_step;
                            else e = sus_target;
                        end
                    end
                end else begin
                    e = sus_target;
                end
            end
            ST_RELEASE: begin
                if (rel_step == 0 || e <= rel_step) begin
                    free_voice(v);
                    return;
                end
                e -= rel_step;
            end
            default: e = 0;
        endcase
        v_env[v] = e;
    endtask

    task automatic predict_voices(note_req_t it);
        int v;
        int n;
        int pick;
        voice_out_t r;
        n = 0;
        pick = -1;
        if (it.req == REQ_NOTE_ON) begin
            if (it.key == 0 || it.pstep == 0) return;
            for (v = 0; v < NV && pick < 0; v++) if (!v_act[v]) pick = v;
            for (v = 0; v < NV && pick < 0; v++) if (v_stg[v] == ST_RELEASE) pick = v;
            if (pick < 0) pick = 0;
            v_act[pick] = 1; v_key[pick] = it.key; v_ph[pick] = 0; v_ps[pick] = it.pstep;
            v_env[pick] = 0; v_stg[pick] = ST_ATTACK; v_sc[pick] = 0; v_pl[pick] = pluck_init;
        end else if (it.req == REQ_NOTE_OFF) begin
            if (it.key == 0) return;
            for (v = 0; v < NV; v++)
                if (v_act[v] && v_key[v] == it.key && v_stg[v] != ST_OFF) v_stg[v] = ST_RELEASE;
        end else if (it.req == REQ_TICK) begin
            for (v = 0; v < NV; v++) begin
                if (!v_act[v]) continue;
                step_env(v);
                if (!v_act[v]) continue;
                v_ph[v] = v_ph[v] + v_ps[v];
                r.vidx = v[4:0]; r.phase = v_ph[v]; r.env = v_env[v][14:0];
                r.pluck = v_pl[v]; r.ringing = 1; r.rcount = 0; r.last = 0;
                voice_exp_q.push_back(r);
                if (v_pl[v] > 0) v_pl[v] = v_pl[v] - 8'd1;
                n++;
            end
            if (n == 0) begin
                r = '0;
                r.last = 1;
                voice_exp_q.push_back(r);
            end else begin
                r = voice_exp_q[voice_exp_q.size()-1];
                r.rcount = n[5:0];
                r.last = 1;
                voice_exp_q[voice_exp_q.size()-1] = r;
            end
        end
    endtask

    // input acceptance, prediction and output checking
    always @(posedge i_clk) begin
        voice_out_t e;
        voice_out_t a;
        note_req_t it;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            a.vidx = o_m_tdata[4:0]; a.phase = o_m_tdata[36:5]; a.env = o_m_tdata[51:37];
            a.pluck = o_m_tdata[59:52]; a.rcount = o_m_tdata[65:60];
            a.ringing = o_m_tuser; a.last = o_m_tlast;
            if (voice_exp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: %p", a);
            end else begin
                e = voice_exp_q.pop_front();
                if (a !== e) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            it.req = t_req'(i_s_tuser);
            it.key = i_s_tdata[5:0];
            it.pstep = i_s_tdata[37:6];
            predict_voices(it);
            n_taken++;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender
    always @(negedge i_clk) begin
        static int gap = 0;
        logic nv;
        note_req_t it;
        nv = i_s_tvalid;
        if (i_s_tvalid && n_taken == n_sent) nv = 0;
        if (!nv && i_rst_n) begin
            if (gap > 0) begin
                gap--;
            end else if (pend_q.size() != 0) begin
                it = pend_q.pop_front();
                i_s_tuser <= it.req;
                i_s_tdata <= {2'b0, it.pstep, it.key};
                nv = 1;
                n_sent++;
                gap = pick_gap();
            end
        end
        i_s_tvalid <= nv;
    end

    // receiver
    always @(negedge i_clk) begin
        static int rgap = 0;
        static int hold_cnt = 0;
        static bit hold_done = 0;
        if (hold_go && !hold_done) begin
            hold_cnt = 2500;
            hold_done = 1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_tready <= 1'b0;
        end else if (rgap > 0) begin
            rgap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20) rgap = pick_gap();
        end
    end

    task automatic cfg_write(t_reg_idx r, logic [31:0] val);
        @(negedge i_clk);
        i_psel <= 1; i_pwrite <= 1; i_penable <= 0;
        i_paddr <= APB_AW'(r) << 2; i_pwdata <= val;
        @(negedge i_clk);
        i_penable <= 1;
        @(negedge i_clk);
        i_psel <= 0; i_penable <= 0; i_pwrite <= 0;
        case (r)
            RG_ATTACK_STEP:  atk_step = val[14:0];
            RG_DECAY_TARGET: dec_target = val[14:0];
            RG_DECAY_STEP:   dec_step = val[14:0];
            RG_SUS_TARGET:   sus_target = val[14:0];
            RG_SUS_STEP:     sus_step = val[14:0];
            RG_SUS_DIV:      sus_div = val[7:0];
            RG_REL_STEP:     rel_step = val[14:0];
            RG_PLUCK:        pluck_init = val[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] level_val(int mode);
        case (mode)
            0: return 0;
            1: return 32'h7fff;
            2: return 16384;
            default: begin
                if ($urandom_range(0, 1)) return $urandom_range(1, 2000);
                return $urandom_range(0, 32767);
            end
        endcase
    endfunction

    task automatic set_levels(int mode);
        cfg_write(RG_ATTACK_STEP, (mode == 3) ? $urandom_range(200, 6000) : level_val(mode));
        cfg_write(RG_DECAY_TARGET, level_val(mode));
        cfg_write(RG_DECAY_STEP, level_val(mode));
        cfg_write(RG_SUS_TARGET, level_val(mode));
        cfg_write(RG_SUS_STEP, level_val(mode));
        cfg_write(RG_SUS_DIV, (mode == 1) ? 255 : (mode == 0) ? 0 : $urandom_range(0, 255));
        cfg_write(RG_REL_STEP, (mode == 3) ? $urandom_range(0, 3000) : level_val(mode));
        cfg_write(RG_PLUCK, (mode == 1) ? 255 : (mode == 0) ? 0 : $urandom_range(0, 255));
    endtask

    task automatic push_req(t_req rq, logic [5:0] k, logic [31:0] ps);
        note_req_t it;
        it.req = rq; it.key = k; it.pstep = ps;
        pend_q.push_back(it);
    endtask

    function automatic logic [5:0] rand_key();
        if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, 8));
    endfunction

    task automatic push_random(int n);
        int i;
        int r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                push_req(REQ_NOTE_ON, rand_key(),
                         ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom()));
            else if (r < 55) push_req(REQ_NOTE_OFF, rand_key(), $urandom());
            else if (r < 95) push_req(REQ_TICK, 6'($urandom_range(0, 63)), $urandom());
            else push_req(REQ_NONE, rand_key(), $urandom());
        end
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || i_s_tvalid || voice_exp_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    initial begin
        int p;
        int i;
        for (i = 0; i < NV; i++) free_voice(i);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: quiet tick, rejected notes, extremes, every request type
        push_req(REQ_TICK, 0, 0);
        push_req(REQ_NOTE_ON, 0, 32'h1234);
        push_req(REQ_NOTE_ON, 5, 0);
        push_req(REQ_NOTE_ON, 63, 32'hffff_ffff);
        push_req(REQ_NOTE_ON, 1, 32'h0000_0001);
        push_req(REQ_NOTE_ON, 63, 32'h8000_0000);
        push_req(REQ_TICK, 63, 32'hffff_ffff);
        push_req(REQ_TICK, 0, 0);
        push_req(REQ_NONE, 63, 32'hffff_ffff);
        push_req(REQ_NOTE_OFF, 0, 0);
        push_req(REQ_NOTE_OFF, 63, 0);
        push_req(REQ_TICK, 0, 0);
        push_req(REQ_NOTE_OFF, 1, 0);
        for (i = 0; i < 6; i++) push_req(REQ_TICK, 0, 0);
        wait_idle();
        set_levels(0);
        push_req(REQ_NOTE_ON, 2, 32'h1);
        push_req(REQ_TICK, 0, 0);
        push_req(REQ_NOTE_OFF, 2, 0);
        push_req(REQ_TICK, 0, 0);
        push_req(REQ_TICK, 0, 0);
        wait_idle();

        // fill every voice, steal, then stall the output for a long stretch
        set_levels(1);
        for (i = 0; i < 34; i++) push_req(REQ_NOTE_ON, 6'($urandom_range(1, 63)), $urandom());
        for (i = 0; i < 12; i++) push_req(REQ_TICK, 0, 0);
        hold_go = 1;
        push_random(20);
        wait_idle();

        for (p = 0; p < 8; p++) begin
            set_levels((p == 0) ? 2 : 3);
            push_random(40);
            wait_idle();
        end

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
